// ----- rtl/ssd_pkg.sv -----
package ssd_pkg;

	// word geometry
	localparam int WORD_BITS   = 32;
	localparam int IDX_BITS    = $clog2(WORD_BITS);
	localparam int QUEUE_DEPTH = 2;

	// reciprocal of ten for 16-bit operands: x / 10 == (x * 0xCCCD) >> 19
	localparam logic [15:0] RECIP10 = 16'hCCCD;
	localparam int          RECIP10_SHIFT = 19;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [3:0]           digit_t;
	typedef logic [IDX_BITS-1:0]  bit_idx_t;

	// queue read side as seen by the back end
	typedef struct packed {
		logic  valid;
		word_t word;
	} q_rd_t;

	// segment pattern, outer positions (PCDE........GFAB)
	function automatic logic [15:0] dig_hi(input digit_t d);
		logic [15:0] p;
		case (d)
			4'd0:    p = 16'h7007;
			4'd1:    p = 16'h4001;
			4'd2:    p = 16'h300B;
			4'd3:    p = 16'h600B;
			4'd4:    p = 16'h400D;
			4'd5:    p = 16'h600E;
			4'd6:    p = 16'h700E;
			4'd7:    p = 16'h4003;
			4'd8:    p = 16'h700F;
			4'd9:    p = 16'h600F;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// segment pattern, middle position (....PCDEGFAB....)
	function automatic logic [15:0] dig_mid(input digit_t d);
		logic [15:0] p;
		case (d)
			4'd0:    p = 16'h0770;
			4'd1:    p = 16'h0410;
			4'd2:    p = 16'h03B0;
			4'd3:    p = 16'h06B0;
			4'd4:    p = 16'h04D0;
			4'd5:    p = 16'h06E0;
			4'd6:    p = 16'h07E0;
			4'd7:    p = 16'h0430;
			4'd8:    p = 16'h07F0;
			4'd9:    p = 16'h06F0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// bar graph, lengths above eight light nothing
	function automatic logic [15:0] bar_pat(input logic [7:0] n);
		logic [15:0] p;
		case (n)
			8'd0:    p = 16'h0000;
			8'd1:    p = 16'h0100;
			8'd2:    p = 16'h0300;
			8'd3:    p = 16'h0700;
			8'd4:    p = 16'h0F00;
			8'd5:    p = 16'h0F80;
			8'd6:    p = 16'h0FC0;
			8'd7:    p = 16'h0FE0;
			8'd8:    p = 16'h0FF0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// one led per mask bit, bar order 4321 5678
	function automatic logic [15:0] mask_pat(input logic [7:0] m);
		logic [15:0] p;
		p = {4'b0000, m[3], m[2], m[1], m[0], m[4], m[5], m[6], m[7], 4'b0000};
		return p;
	endfunction

	function automatic logic [15:0] led_pat(input logic mode, input logic [7:0] led);
		return mode ? mask_pat(led) : bar_pat(led);
	endfunction

endpackage

// ----- rtl/ssd_front.sv -----
module ssd_front import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] value,
	input  logic [7:0]  led,
	output logic        push,
	output word_t       push_word,
	input  logic        full
);

	// stage registers
	logic        v_s1, v_s2, v_s3;
	logic [12:0] q1_s1;
	logic [9:0]  q2_s2;
	digit_t      units_s1, units_s2;
	digit_t      tens_s2;
	logic        mode_s1, mode_s2;
	logic [7:0]  led_s1, led_s2;
	word_t       word_s3;

	logic        rdy_s1, rdy_s2, rdy_s3;
	logic [31:0] prod1, prod2, prod3;
	logic [15:0] q1x10;
	logic [12:0] q2x10;
	logic [9:0]  q3x10;
	logic [12:0] q1;
	logic [9:0]  q2;
	logic [6:0]  q3;
	digit_t      units, tens, hundreds;
	word_t       word;

	// per-stage flow control
	assign rdy_s3   = !v_s3 || !full;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign push      = v_s3 && !full;
	assign push_word = word_s3;

	// units digit
	always_comb begin
		prod1 = 32'(value) * 32'(RECIP10);
		q1    = prod1[RECIP10_SHIFT +: 13];
		q1x10 = (16'(q1) << 3) + (16'(q1) << 1);
		units = 4'(value - q1x10);
	end

	// tens digit
	always_comb begin
		prod2 = 32'(q1_s1) * 32'(RECIP10);
		q2    = prod2[RECIP10_SHIFT +: 10];
		q2x10 = (13'(q2) << 3) + (13'(q2) << 1);
		tens  = 4'(q1_s1 - q2x10);
	end

	// hundreds digit and word assembly
	always_comb begin
		prod3    = 32'(q2_s2) * 32'(RECIP10);
		q3       = prod3[RECIP10_SHIFT +: 7];
		q3x10    = (10'(q3) << 3) + (10'(q3) << 1);
		hundreds = 4'(q2_s2 - q3x10);
		word     = ({dig_hi(hundreds), 16'h0000})
			| {16'h0000, dig_mid(tens_s2)}
			| {16'h0000, dig_hi(units_s2)}
			| {led_pat(mode_s2, led_s2), 16'h0000};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			q1_s1    <= q1;
			units_s1 <= units;
			mode_s1  <= mode;
			led_s1   <= led;
		end
		if (rdy_s2) begin
			q2_s2    <= q2;
			tens_s2  <= tens;
			units_s2 <= units_s1;
			mode_s2  <= mode_s1;
			led_s2   <= led_s1;
		end
		if (rdy_s3) begin
			word_s3 <= word;
		end
	end

endmodule

// ----- rtl/ssd_fifo.sv -----
module ssd_fifo import ssd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t push_word,
	output logic  full,
	input  logic  pop,
	output q_rd_t rd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	word_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.word  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)  rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_word;
	end

endmodule

// ----- rtl/ssd_back.sv -----
module ssd_back import ssd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  q_rd_t rd,
	output logic  pop,
	output logic  out_valid,
	input  logic  out_stall,
	output logic  serial_bit,
	output logic  latch_last,
	output word_t full_word
);

	logic     have_q;
	word_t    sh_q;
	bit_idx_t idx_q;
	logic     out_valid_q;
	logic     bit_q, last_q;
	word_t    word_q;

	logic adv, last_bit, load;

	assign adv      = !out_valid_q || !out_stall;
	assign last_bit = idx_q == IDX_BITS'(WORD_BITS - 1);
	assign load     = rd.valid && (!have_q || (adv && last_bit));
	assign pop      = load;

	assign out_valid  = out_valid_q;
	assign serial_bit = bit_q;
	assign latch_last = last_q;
	assign full_word  = word_q;

	// bit sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) out_valid_q <= have_q;
			if (load) begin
				have_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv && have_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_bit) have_q <= 1'b0;
			end
		end
	end

	// word holding and output payload
	always_ff @(posedge clk) begin
		if (load) sh_q <= rd.word;
		if (adv && have_q) begin
			bit_q  <= sh_q[idx_q];
			last_q <= last_bit;
			word_q <= sh_q;
		end
	end

endmodule

// ----- rtl/seven_segment_serial_driver.sv -----
// Three-digit seven-segment serial driver.
// Input channel (in_valid / in_stall): one word carries mode, value and led.
// The three low decimal digits of value and the led pattern (bar length in
// mode 0, bitmask in mode 1) are packed into a 32-bit display pattern.
// Output channel (out_valid / out_stall): 32 words per input word, one
// pattern bit each, LSB first; latch_last marks the 32nd bit and full_word
// carries the whole pattern in every one of them.
// Path of a word: three digit-split stages, the queue, the shifter's
// holding register and the output register.
// Throughput: one bit per cycle while the output is not stalled, set by
// the back-end shifter; following words are shifted without a gap.
// The front end keeps accepting while the queue has room, so up to the
// queue depth plus three words may wait behind the one being shifted.
// A stall on the output holds the current bit and stops the shifter; the
// front end then fills and raises in_stall.
// Reset empties all stages and the queue; no word is in flight afterwards.
module seven_segment_serial_driver import ssd_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] value,
	input  logic [7:0]  led,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        serial_bit,
	output logic        latch_last,
	output logic [31:0] full_word
);

	logic  push, full, pop;
	word_t push_word;
	q_rd_t rd;

	// digit split and pattern build
	ssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.led       (led),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	// pattern queue between front and shifter
	ssd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.rd        (rd)
	);

	// serial shifter
	ssd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd         (rd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.serial_bit (serial_bit),
		.latch_last (latch_last),
		.full_word  (full_word)
	);

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BAR_MAX       = 8;
	localparam int RANDOM_WORDS  = 185;
	localparam int BURST_WORDS   = 14;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 500000;

	typedef enum logic {
		BAR_MODE  = 1'b0,
		MASK_MODE = 1'b1
	} led_mode_t;

	// expected serial stream, one entry per shifted bit
	class display_scoreboard;
		typedef struct {
			logic        serial;
			logic        last;
			logic [31:0] pattern;
		} shift_bit_t;

		shift_bit_t  pending[$];
		int          errors;
		int          bar_words;
		int          mask_words;
		int          bits_seen;

		// outer digit positions, PCDE........GFAB
		logic [15:0] outer_seg [10] = '{16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
			16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F};
		// middle digit position, ....PCDEGFAB....
		logic [15:0] middle_seg [10] = '{16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
			16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0};
		// bar graph by length
		logic [15:0] bar_seg [9] = '{16'h0000, 16'h0100, 16'h0300, 16'h0700, 16'h0F00,
			16'h0F80, 16'h0FC0, 16'h0FE0, 16'h0FF0};
		// one lamp per mask bit
		logic [15:0] lamp_seg [8] = '{16'h0100, 16'h0200, 16'h0400, 16'h0800,
			16'h0080, 16'h0040, 16'h0020, 16'h0010};

		function logic [31:0] display_pattern(led_mode_t m, logic [15:0] v, logic [7:0] l);
			logic [31:0] w;
			int          hundreds;
			int          tens;
			int          units;
			hundreds = (v / 100) % 10;
			tens     = (v / 10) % 10;
			units    = v % 10;
			w = {outer_seg[hundreds], 16'h0000} | {16'h0000, middle_seg[tens]} |
				{16'h0000, outer_seg[units]};
			// lamps ride in the upper half
			if (m == BAR_MODE) begin
				if (l <= BAR_MAX)
					w |= {bar_seg[l], 16'h0000};
			end else begin
				for (int i = 0; i < 8; i++)
					if (l[i])
						w |= {lamp_seg[i], 16'h0000};
			end
			return w;
		endfunction

		function void note_word(led_mode_t m, logic [15:0] v, logic [7:0] l);
			logic [31:0] w;
			shift_bit_t  e;
			w = display_pattern(m, v, l);
			if (m == BAR_MODE)
				bar_words++;
			else
				mask_words++;
			for (int k = 0; k < 32; k++) begin
				e.serial  = w[k];
				e.last    = (k == 31);
				e.pattern = w;
				pending.push_back(e);
			end
		endfunction

		function void check_bit(logic serial, logic last, logic [31:0] pattern);
			shift_bit_t e;
			bits_seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected bit, serial %b last %b word %h",
					$time, serial, last, pattern);
				return;
			end
			e = pending.pop_front();
			if (serial !== e.serial) begin
				errors++;
				$display("%0t: serial_bit expected %b actual %b", $time, e.serial, serial);
			end
			if (last !== e.last) begin
				errors++;
				$display("%0t: latch_last expected %b actual %b", $time, e.last, last);
			end
			if (pattern !== e.pattern) begin
				errors++;
				$display("%0t: full_word expected %h actual %h", $time, e.pattern, pattern);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [15:0] value;
	logic [7:0]  led;
	logic        out_valid;
	logic        out_stall;
	logic        serial_bit;
	logic        latch_last;
	logic [31:0] full_word;

	display_scoreboard sb = new();
	bit                hold_req = 1'b0;
	bit                hold_on  = 1'b0;
	int                cycles   = 0;
	int                input_backed_up = 0;

	seven_segment_serial_driver i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.value      (value),
		.led        (led),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.serial_bit (serial_bit),
		.latch_last (latch_last),
		.full_word  (full_word)
	);

	always #5 clk = ~clk;

	// cycle count and watchdog
	always @(posedge clk) begin
		cycles++;
		if (in_valid && in_stall)
			input_backed_up++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d bits outstanding", $time, sb.pending.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// compare every accepted output bit
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_bit(serial_bit, latch_last, full_word);
	end

	// offer one word and hold it until taken
	task automatic send_word(led_mode_t m, logic [15:0] v, logic [7:0] l);
		@(negedge clk);
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		led      <= l;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(m, v, l);
	endtask

	// drop valid for a number of cycles
	task automatic pause_input(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int input_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_random_word();
		led_mode_t   m;
		logic [15:0] v;
		logic [7:0]  l;
		int          r;
		m = $urandom_range(0, 1) ? MASK_MODE : BAR_MODE;
		v = ($urandom_range(0, 9) < 5) ? 16'($urandom_range(0, 999)) :
			16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (m == BAR_MODE && r < 70)
			l = 8'($urandom_range(0, BAR_MAX));
		else if (m == BAR_MODE && r < 85)
			l = 8'($urandom_range(BAR_MAX + 1, 15));
		else
			l = 8'($urandom_range(0, 255));
		send_word(m, v, l);
	endtask

	// receiver: random stall bursts, runs without stall, one long hold-off
	initial begin
		int stall_len;
		int run_len;
		int r;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				out_stall <= 1'b1;
				hold_req = 1'b0;
				hold_on  = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_on = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				stall_len = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) :
					$urandom_range(8, 20);
				if (stall_len > 0) begin
					@(negedge clk);
					out_stall <= 1'b1;
					repeat (stall_len - 1) @(negedge clk);
				end
			end
			@(negedge clk);
			out_stall <= 1'b0;
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 12);
			for (int i = 1; i < run_len && !hold_req; i++)
				@(negedge clk);
		end
	end

	// reset, directed words, random words, drain
	initial begin
		in_valid = 1'b0;
		mode     = 1'b0;
		value    = '0;
		led      = '0;
		arst_n   = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// every digit in every position, blank and full values, digit eight everywhere
		send_word(BAR_MODE, 16'd147, 8'd0);
		send_word(BAR_MODE, 16'd258, 8'd1);
		send_word(BAR_MODE, 16'd369, 8'd2);
		pause_input(3);
		send_word(BAR_MODE, 16'd470, 8'd3);
		send_word(BAR_MODE, 16'd581, 8'd4);
		send_word(BAR_MODE, 16'd692, 8'd5);
		send_word(BAR_MODE, 16'd703, 8'd6);
		send_word(BAR_MODE, 16'd814, 8'd7);
		send_word(BAR_MODE, 16'd925, 8'd8);
		// bar lengths past eight light nothing
		send_word(BAR_MODE, 16'd36, 8'd9);
		send_word(BAR_MODE, 16'd888, 8'd255);
		send_word(BAR_MODE, 16'd0, 8'd128);
		pause_input(20);
		send_word(MASK_MODE, 16'd65535, 8'h00);
		send_word(MASK_MODE, 16'd999, 8'hFF);
		send_word(MASK_MODE, 16'd1000, 8'h01);
		send_word(MASK_MODE, 16'd65000, 8'h80);
		send_word(MASK_MODE, 16'd888, 8'hA5);
		send_word(MASK_MODE, 16'd8, 8'h5A);
		send_word(MASK_MODE, 16'd80, 8'h0F);
		send_word(MASK_MODE, 16'd800, 8'hF0);
		send_word(MASK_MODE, 16'd0, 8'h00);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 40) begin
				// hold the output and keep offering so the input backs up
				hold_req = 1'b1;
				wait (hold_on);
				for (int b = 0; b < BURST_WORDS; b++)
					send_random_word();
			end
			send_random_word();
			pause_input(input_gap());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words (%0d bar, %0d mask lamps), %0d serial bits compared",
			sb.bar_words + sb.mask_words, sb.bar_words, sb.mask_words, sb.bits_seen);
		$display("input was held back for %0d cycles, %0d mismatches",
			input_backed_up, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_fifo.sv
rtl/ssd_back.sv
rtl/seven_segment_serial_driver.sv
bench/tb_top.sv
